FILE: design/adts_pkg.sv
// shared constants, codes and the command type for the adts frame extractor
// no dependencies; imported by the parser, command queue, emitter and top level
package adts_pkg;

   localparam int HdrLen = 6;
   localparam int LenW = 13;
   localparam int ByteW = 8;
   localparam int QDepth = 8;
   localparam int QPtrW = $clog2(QDepth);
   localparam int QCntW = $clog2(QDepth + 1);
   localparam int IdxW = $clog2(HdrLen);

   localparam logic [LenW-1:0] MinLen = 13'd7;
   localparam logic [ByteW-1:0] SyncByte = 8'hFF;
   localparam logic [3:0] SyncNibble = 4'hF;

   localparam logic [1:0] PH_HUNT0 = 2'd0;
   localparam logic [1:0] PH_HUNT1 = 2'd1;
   localparam logic [1:0] PH_HEAD = 2'd2;
   localparam logic [1:0] PH_BODY = 2'd3;

   localparam logic [1:0] KIND_BODY = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR = 2'd2;

   localparam logic [IdxW-1:0] LastHdrIdx = IdxW'(HdrLen - 1);

   typedef struct packed {
      logic [1:0] kind;
      logic last;
      logic [LenW-1:0] len;
      logic [HdrLen*ByteW-1:0] bytes;
   } adts_cmd_type;

endpackage

FILE: design/adts_parser.sv
// front end: sync hunt, header collection and body byte classification
// depends on adts_pkg; pushes one command per producing byte into adts_cmd_queue
module adts_parser (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [adts_pkg::ByteW-1:0] req_tdata,
   input  logic q_full,
   output logic push,
   output adts_pkg::adts_cmd_type push_cmd
);
   import adts_pkg::*;

   logic [1:0] phase_ff, phase_in;
   logic [LenW-1:0] count_ff, count_in;
   logic [LenW-1:0] len_ff, len_in;
   logic [ByteW-1:0] hdr_ff [0:HdrLen-2];
   logic accept;
   logic [LenW-1:0] hdr_len;
   logic [LenW-1:0] count_inc;

   assign req_tready = !q_full;
   assign accept = req_tvalid && req_tready;
   assign hdr_len = {hdr_ff[3][1:0], hdr_ff[4], req_tdata[7:5]};
   assign count_inc = count_ff + 13'd1;

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in = len_ff;
      push = 1'b0;
      push_cmd.kind = KIND_BODY;
      push_cmd.last = 1'b0;
      push_cmd.len = len_ff;
      push_cmd.bytes = {{((HdrLen-1)*ByteW){1'b0}}, req_tdata};
      if (accept) begin
         case (phase_ff)
            PH_HUNT0: begin
               if (req_tdata == SyncByte) phase_in = PH_HUNT1;
            end
            PH_HUNT1: begin
               if (req_tdata[7:4] == SyncNibble) begin
                  phase_in = PH_HEAD;
                  count_in = 13'd2;
               end else begin
                  phase_in = PH_HUNT0;
               end
            end
            PH_HEAD: begin
               if (count_ff < 13'd5) begin
                  count_in = count_inc;
               end else begin
                  len_in = hdr_len;
                  push = 1'b1;
                  push_cmd.len = hdr_len;
                  if (hdr_len < MinLen) begin
                     push_cmd.kind = KIND_ERROR;
                     push_cmd.last = 1'b1;
                     count_in = '0;
                     phase_in = PH_HUNT0;
                  end else begin
                     push_cmd.kind = KIND_HEADER;
                     push_cmd.bytes = {req_tdata, hdr_ff[4], hdr_ff[3], hdr_ff[2],
                                       hdr_ff[1], hdr_ff[0]};
                     count_in = 13'(HdrLen);
                     phase_in = PH_BODY;
                  end
               end
            end
            default: begin
               push = 1'b1;
               if (count_inc >= len_ff) begin
                  push_cmd.last = 1'b1;
                  count_in = '0;
                  phase_in = PH_HUNT0;
               end else begin
                  count_in = count_inc;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT0;
         count_ff <= '0;
         len_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         case (phase_ff)
            PH_HUNT0: hdr_ff[0] <= req_tdata;
            PH_HUNT1: hdr_ff[1] <= req_tdata;
            PH_HEAD: begin
               if (count_ff < 13'd5) hdr_ff[count_ff[IdxW-1:0]] <= req_tdata;
            end
            default: ;
         endcase
      end
   end

   a_head_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEAD |-> (count_ff >= 13'd2 && count_ff <= 13'd5))
      else $error("header count out of range");
   a_body_len: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_BODY |-> (len_ff >= MinLen && count_ff < len_ff))
      else $error("body count past frame length");
   a_push_accept: assert property (@(posedge clock) disable iff (reset)
      push |-> accept && (phase_ff == PH_HEAD || phase_ff == PH_BODY))
      else $error("command pushed without a producing item");

endmodule

FILE: design/adts_cmd_queue.sv
// small register queue of commands between the parser and the emitter
// depends on adts_pkg for the command type and depth
module adts_cmd_queue (
   input  logic clock,
   input  logic reset,
   input  logic push,
   input  adts_pkg::adts_cmd_type push_cmd,
   output logic full,
   input  logic pop,
   output logic q_valid,
   output adts_pkg::adts_cmd_type q_cmd
);
   import adts_pkg::*;

   adts_cmd_type mem_ff [0:QDepth-1];
   logic [QPtrW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPtrW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCntW-1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full = cnt_ff == QCntW'(QDepth);
   assign q_valid = cnt_ff != '0;
   assign q_cmd = mem_ff[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop = pop && q_valid;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) cnt_in = cnt_ff + 1'b1;
      else if (!do_push && do_pop) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) mem_ff[wr_ptr_ff] <= push_cmd;
   end

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCntW'(QDepth))
      else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      !(push && full))
      else $error("push into full queue");
   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      QPtrW'(wr_ptr_ff - rd_ptr_ff) == cnt_ff[QPtrW-1:0])
      else $error("queue pointers disagree with count");

endmodule

FILE: design/adts_emitter.sv
// back end: expands queued commands into result items and holds the output
// depends on adts_pkg; fed by adts_cmd_queue
module adts_emitter (
   input  logic clock,
   input  logic reset,
   input  logic q_valid,
   input  adts_pkg::adts_cmd_type q_cmd,
   output logic pop,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,
   output logic rsp_tlast,
   output logic [1:0] rsp_tuser
);
   import adts_pkg::*;

   adts_cmd_type cur_ff;
   logic cur_valid_ff, cur_valid_in;
   logic [IdxW-1:0] idx_ff, idx_in;
   logic fire, last_beat;
   logic [ByteW-1:0] out_byte;
   logic is_hdr, is_err;

   assign is_hdr = cur_ff.kind == KIND_HEADER;
   assign is_err = cur_ff.kind == KIND_ERROR;
   assign fire = cur_valid_ff && rsp_tready;
   assign last_beat = !is_hdr || idx_ff == LastHdrIdx;
   assign pop = q_valid && (!cur_valid_ff || (fire && last_beat));

   always_comb begin
      case (idx_ff)
         3'd0: out_byte = cur_ff.bytes[7:0];
         3'd1: out_byte = cur_ff.bytes[15:8];
         3'd2: out_byte = cur_ff.bytes[23:16];
         3'd3: out_byte = cur_ff.bytes[31:24];
         3'd4: out_byte = cur_ff.bytes[39:32];
         3'd5: out_byte = cur_ff.bytes[47:40];
         default: out_byte = '0;
      endcase
      if (is_err) out_byte = '0;
   end

   always_comb begin
      cur_valid_in = cur_valid_ff;
      idx_in = idx_ff;
      if (pop) begin
         cur_valid_in = 1'b1;
         idx_in = '0;
      end else if (fire) begin
         if (last_beat) cur_valid_in = 1'b0;
         else idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         idx_ff <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         idx_ff <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= q_cmd;
   end

   // tdata: out_byte, frame_length, zero pad; tuser: frame_start, length_error
   assign rsp_tvalid = cur_valid_ff;
   assign rsp_tdata = {3'b000, cur_ff.len, out_byte};
   assign rsp_tlast = is_err || (cur_ff.kind == KIND_BODY && cur_ff.last);
   assign rsp_tuser = {is_err, is_err || (is_hdr && idx_ff == '0)};

   a_idx_range: assert property (@(posedge clock) disable iff (reset)
      cur_valid_ff |-> idx_ff <= LastHdrIdx)
      else $error("header beat index out of range");
   a_idx_hdr_only: assert property (@(posedge clock) disable iff (reset)
      (cur_valid_ff && idx_ff != '0) |-> is_hdr)
      else $error("multi-beat index on single-beat command");
   a_idx_step: assert property (@(posedge clock) disable iff (reset)
      (fire && !last_beat) |=> cur_valid_ff && idx_ff == $past(idx_ff) + 1'b1)
      else $error("header beat skipped");

endmodule

FILE: design/adts_frame_extractor.sv
// adts frame extractor: result items pass through the command queue and the emitter
// one byte per cycle in, one item per cycle out while the sink is ready; a header
// command gives six items; the queue holds 8 commands and input stalls only when full
// reset is synchronous, active high: sync hunt restarts, queue and output are emptied
// depends on adts_pkg, adts_parser, adts_cmd_queue and adts_emitter
module adts_frame_extractor (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,  // out_byte, frame_length, zero pad
   output logic rsp_tlast,         // frame_end
   output logic [1:0] rsp_tuser    // frame_start, length_error
);
   import adts_pkg::*;

   logic push, q_full, pop, q_valid;
   adts_cmd_type push_cmd, q_cmd;

   adts_parser u_parser (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .q_full(q_full),
      .push(push),
      .push_cmd(push_cmd)
   );

   adts_cmd_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_cmd(push_cmd),
      .full(q_full),
      .pop(pop),
      .q_valid(q_valid),
      .q_cmd(q_cmd)
   );

   adts_emitter u_emitter (
      .clock(clock),
      .reset(reset),
      .q_valid(q_valid),
      .q_cmd(q_cmd),
      .pop(pop),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

endmodule

FILE: bench/adts_frame_checker.sv
// checker for the adts frame extractor: follows the sync and header state of the byte stream,
// predicts every result item and compares each accepted item with the oldest prediction
// depends on adts_pkg; instantiated beside the block by adts_frame_extractor_tb
module adts_frame_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   input  logic [7:0] req_tdata,   // data_byte
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   input  logic [23:0] rsp_tdata,  // out_byte, frame_length, zero pad
   input  logic rsp_tlast,         // frame_end
   input  logic [1:0] rsp_tuser,   // frame_start, length_error
   output int mismatches,
   output int frames_due
);
   timeunit 1ns;
   timeprecision 1ps;
   import adts_pkg::*;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic first;
      logic last;
      logic [LenW-1:0] len;
      logic err;
   } frame_byte_type;

   frame_byte_type due_bytes[$];
   logic [1:0] sync_phase;
   logic [ByteW-1:0] held_hdr [0:HdrLen-1];
   logic [LenW-1:0] byte_count;
   logic [LenW-1:0] frame_len;

   function automatic frame_byte_type make_item(logic [ByteW-1:0] data, logic first,
                                                logic last, logic [LenW-1:0] len,
                                                logic err);
      frame_byte_type it;
      it.data = data;
      it.first = first;
      it.last = last;
      it.len = len;
      it.err = err;
      return it;
   endfunction

   task automatic extract_byte(input logic [ByteW-1:0] b);
      logic [LenW-1:0] len;
      case (sync_phase)
         PH_HUNT0: begin
            if (b == SyncByte) begin
               held_hdr[0] = b;
               sync_phase = PH_HUNT1;
            end
         end
         PH_HUNT1: begin
            if (b[7:4] == SyncNibble) begin
               held_hdr[1] = b;
               byte_count = LenW'(2);
               sync_phase = PH_HEAD;
            end else begin
               sync_phase = PH_HUNT0;
            end
         end
         PH_HEAD: begin
            held_hdr[byte_count] = b;
            if (byte_count < LenW'(HdrLen - 1)) begin
               byte_count = byte_count + 1'b1;
            end else begin
               len = {held_hdr[3][1:0], held_hdr[4], held_hdr[5][7:5]};
               frame_len = len;
               if (len < MinLen) begin
                  due_bytes.push_back(make_item('0, 1'b1, 1'b1, len, 1'b1));
                  byte_count = '0;
                  sync_phase = PH_HUNT0;
               end else begin
                  for (int i = 0; i < HdrLen; i++)
                     due_bytes.push_back(make_item(held_hdr[i], i == 0, 1'b0, len, 1'b0));
                  byte_count = LenW'(HdrLen);
                  sync_phase = PH_BODY;
               end
            end
         end
         default: begin
            byte_count = byte_count + 1'b1;
            if (byte_count >= frame_len) begin
               due_bytes.push_back(make_item(b, 1'b0, 1'b1, frame_len, 1'b0));
               byte_count = '0;
               sync_phase = PH_HUNT0;
            end else begin
               due_bytes.push_back(make_item(b, 1'b0, 1'b0, frame_len, 1'b0));
            end
         end
      endcase
   endtask

   always @(posedge clock) begin
      frame_byte_type got;
      frame_byte_type want;
      if (reset) begin
         due_bytes.delete();
         sync_phase = PH_HUNT0;
         byte_count = '0;
         frame_len = '0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = make_item(rsp_tdata[7:0], rsp_tuser[0], rsp_tlast, rsp_tdata[20:8],
                            rsp_tuser[1]);
            if (due_bytes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t unexpected item: byte %02h start %0d end %0d len %0d err %0d",
                           $time, got.data, got.first, got.last, got.len, got.err);
            end else begin
               want = due_bytes.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("%0t mismatch: expected byte %02h start %0d end %0d len %0d err %0d",
                              $time, want.data, want.first, want.last, want.len, want.err);
                     $display("%0t          got byte %02h start %0d end %0d len %0d err %0d",
                              $time, got.data, got.first, got.last, got.len, got.err);
                  end
               end
            end
         end
         if (req_tvalid && req_tready)
            extract_byte(req_tdata);
      end
      frames_due = due_bytes.size();
   end

endmodule

FILE: bench/adts_frame_extractor_tb.sv
// testbench top for the adts frame extractor: clock, reset and a byte stream of directed
// and random adts frames, noise and broken syncs; the verdict comes from adts_frame_checker
// depends on adts_pkg, adts_frame_extractor and adts_frame_checker
module adts_frame_extractor_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import adts_pkg::*;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [7:0] req_tdata = 8'h00;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [23:0] rsp_tdata;
   logic rsp_tlast;
   logic [1:0] rsp_tuser;

   int mismatches;
   int frames_due;
   int bytes_sent = 0;
   bit sender_steady = 1'b0;

   localparam int NumOpening = 22;
   logic [7:0] opening [0:NumOpening-1] = '{
      8'h00, 8'hFF, 8'h12,
      8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hC0,
      8'hFF, 8'hF1, 8'h50, 8'h80, 8'h00, 8'hE0, 8'hFF,
      8'hFF, 8'hF0, 8'hFF, 8'hFC, 8'h00, 8'h1F
   };

   always #10 clock = ~clock;

   adts_frame_extractor DUT (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   adts_frame_checker checker_i (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .mismatches(mismatches),
      .frames_due(frames_due)
   );

   // sink stalls at random, apart from the steady stretch
   always @(negedge clock) begin
      if (sender_steady)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= ($urandom_range(99) >= 35);
   end

   task automatic send_byte(input logic [7:0] b);
      while (!sender_steady && $urandom_range(99) < 35) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= b;
      do @(posedge clock); while (!req_tready);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (frames_due != 0) @(negedge clock);
   endtask

   task automatic send_frame(input logic [LenW-1:0] flen);
      logic [7:0] b3;
      logic [7:0] b5;
      b3 = {6'($urandom_range(63)), flen[12:11]};
      b5 = {flen[2:0], 5'($urandom_range(31))};
      send_byte(SyncByte);
      send_byte({SyncNibble, 4'($urandom_range(15))});
      send_byte(8'($urandom_range(255)));
      send_byte(b3);
      send_byte(flen[10:3]);
      send_byte(b5);
      for (int i = HdrLen; i < flen; i++)
         send_byte(8'($urandom_range(255)));
   endtask

   initial begin
      int pick;
      bit held_off;
      held_off = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int i = 0; i < NumOpening; i++)
         send_byte(opening[i]);
      drain_results();

      while (bytes_sent < 120) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            // noise without sync bytes keeps the stream aligned
            repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(254)));
         end else if (pick < 18) begin
            send_byte(SyncByte);
            send_byte({4'($urandom_range(14)), 4'($urandom_range(15))});
         end else if (pick < 30) begin
            send_frame(LenW'($urandom_range(6)));
         end else if (pick < 92) begin
            send_frame(LenW'($urandom_range(7, 24)));
         end else begin
            send_frame(LenW'($urandom_range(25, 40)));
         end
         if (!held_off && bytes_sent >= 70) begin
            drain_results();
            held_off = 1'b1;
         end
      end

      // one frame sent back to back into a sink that never stalls
      sender_steady = 1'b1;
      send_frame(LenW'(32));
      sender_steady = 1'b0;

      req_tvalid <= 1'b0;
      while (frames_due != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (mismatches == 0 && frames_due == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb: failure");
      $finish;
   end

endmodule
